// ===== hdl/pstf_pkg.sv =====
package pstf_pkg;

  typedef enum logic [2:0] {
    ENC_U8    = 3'd0,
    ENC_S8    = 3'd1,
    ENC_S16   = 3'd2,
    ENC_S24   = 3'd3,
    ENC_S32   = 3'd4,
    ENC_F32   = 3'd5,
    ENC_F64   = 3'd6,
    ENC_NONE  = 3'd7
  } enc_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 1'd1;

  // float32 from a signed 32-bit integer times 2^-(scale), round to nearest even
  function automatic logic [31:0] int_to_f32(input logic [31:0] v, input logic [7:0] scale);
    logic        s;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic        found;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic [8:0]  ex;
    s = v[31];
    mag = s ? (~v + 32'd1) : v;
    lz = 5'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && mag[i]) begin
        found = 1'b1;
        lz = 5'(31 - i);
      end
    end
    norm = mag << lz;
    mant = norm[31:8];
    g = norm[7];
    st = |norm[6:0];
    rnd = {1'b0, mant} + 25'(g & (st | mant[0]));
    // exponent of msb is 31-lz, minus scale, plus bias 127
    ex = 9'd158 - 9'(lz) - 9'(scale) + 9'(rnd[24]);
    if (!found) begin
      int_to_f32 = 32'd0;
    end else if (rnd[24]) begin
      int_to_f32 = {s, ex[7:0], 23'd0};
    end else begin
      int_to_f32 = {s, ex[7:0], rnd[22:0]};
    end
  endfunction

endpackage

// ===== hdl/pstf_f64_narrow.sv =====
module pstf_f64_narrow (
  input  logic [63:0] d,
  output logic [31:0] f
);

  logic        s;
  logic [10:0] e;
  logic [51:0] m;
  logic signed [12:0] ue;
  logic [52:0] sig;
  logic [5:0]  sh;
  logic [52:0] shifted;
  logic        lost;
  logic [23:0] kept;
  logic        g;
  logic        st;
  logic [24:0] rnd;
  logic [8:0]  be;
  logic [8:0]  be_fin;

  always_comb begin
    s = d[63];
    e = d[62:52];
    m = d[51:0];
    ue = 13'(e) - 13'sd896;
    sig = {1'b1, m};
    f = {s, 31'd0};
    sh = '0;
    shifted = '0;
    lost = 1'b0;
    kept = '0;
    g = 1'b0;
    st = 1'b0;
    rnd = '0;
    be = '0;
    be_fin = '0;
    if (e == 11'h7ff) begin
      f = 32'd0;
    end else if (e == 11'd0 || ue < -13'sd24) begin
      // f64 subnormals and tiny values round to signed zero
      f = {s, 31'd0};
    end else if (ue >= 13'sd255) begin
      f = {s, 8'hff, 23'd0};
    end else begin
      if (ue >= 13'sd1) begin
        sh = 6'd0;
        be = 9'(ue);
      end else begin
        sh = 6'(13'sd1 - ue);
        be = 9'd0;
      end
      shifted = sig >> sh;
      lost = |(sig & ~(53'h1f_ffff_ffff_ffff << sh));
      kept = shifted[52:29];
      g = shifted[28];
      st = (|shifted[27:0]) | lost;
      rnd = {1'b0, kept} + 25'(g & (st | kept[0]));
      if (be == 9'd0) begin
        // subnormal: carry into bit 23 makes the smallest normal
        f = {s, 7'd0, rnd[23], rnd[22:0]};
      end else begin
        be_fin = be + 9'(rnd[24]);
        if (be_fin >= 9'd255) begin
          f = {s, 8'hff, 23'd0};
        end else begin
          f = {s, be_fin[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
        end
      end
    end
  end

endmodule

// ===== hdl/pcm_sample_to_float32_unit.sv =====
// pcm sample to float32 conversion
// in_valid/in_ready carries one item of raw sample bytes (file order, first
// byte in bits 7:0); out_valid/out_ready returns the float32 bit pattern.
// cfg_we with cfg_idx selects register 0 (sample encoding) or 1 (big endian);
// write only while no item is in flight.
// the item sits in the input register and the conversion feeds the result
// register, whose valid flag drives out_valid.
// throughput: one item per clock; both stages advance whenever the stage
// after them is empty or being emptied.
// when out_ready is low the result register holds its item and the input
// register fills; ready then drops until the receiver takes the result.
// reset empties both stages and sets encoding to s16, little endian.
module pcm_sample_to_float32_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_raw_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_float
);

  pstf_pkg::enc_t enc_r;
  logic           be_r;
  logic           v1_r;
  logic [63:0]    raw_r;
  logic           v2_r;
  logic [31:0]    res_r;
  logic           adv2;
  logic [63:0]    w;
  logic [31:0]    res_nxt;
  logic [31:0]    f64_res;

  assign adv2      = v1_r && (!v2_r || out_ready);
  assign in_ready  = !v1_r || adv2;
  assign out_valid = v2_r;
  assign out_sample_float = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= pstf_pkg::ENC_S16;
      be_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == pstf_pkg::REG_ENCODING) enc_r <= pstf_pkg::enc_t'(cfg_wdata);
      else be_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (adv2) v2_r <= 1'b1;
      else if (out_ready) v2_r <= 1'b0;
    end
    if (in_ready && in_valid) raw_r <= in_raw_bytes;
    if (adv2) res_r <= res_nxt;
  end

  // byte assembly into a right-aligned word
  always_comb begin
    w = raw_r;
    if (be_r) begin
      case (enc_r)
        pstf_pkg::ENC_S16: w = {48'd0, raw_r[7:0], raw_r[15:8]};
        pstf_pkg::ENC_S24: w = {40'd0, raw_r[7:0], raw_r[15:8], raw_r[23:16]};
        pstf_pkg::ENC_S32, pstf_pkg::ENC_F32:
          w = {32'd0, raw_r[7:0], raw_r[15:8], raw_r[23:16], raw_r[31:24]};
        pstf_pkg::ENC_F64:
          w = {raw_r[7:0], raw_r[15:8], raw_r[23:16], raw_r[31:24],
               raw_r[39:32], raw_r[47:40], raw_r[55:48], raw_r[63:56]};
        default: w = raw_r;
      endcase
    end
  end

  pstf_f64_narrow u_f64 (
    .d (w),
    .f (f64_res)
  );

  always_comb begin
    case (enc_r)
      // flipping the top bit and sign-extending gives the byte minus 128
      pstf_pkg::ENC_U8:
        res_nxt = pstf_pkg::int_to_f32({{24{~w[7]}}, ~w[7], w[6:0]}, 8'd7);
      pstf_pkg::ENC_S8:  res_nxt = pstf_pkg::int_to_f32({{24{w[7]}}, w[7:0]}, 8'd7);
      pstf_pkg::ENC_S16: res_nxt = pstf_pkg::int_to_f32({{16{w[15]}}, w[15:0]}, 8'd15);
      pstf_pkg::ENC_S24: res_nxt = pstf_pkg::int_to_f32({{8{w[23]}}, w[23:0]}, 8'd23);
      pstf_pkg::ENC_S32: res_nxt = pstf_pkg::int_to_f32(w[31:0], 8'd31);
      pstf_pkg::ENC_F32: res_nxt = (w[30:23] == 8'hff) ? 32'd0 : w[31:0];
      pstf_pkg::ENC_F64: res_nxt = f64_res;
      default:           res_nxt = 32'd0;
    endcase
  end

endmodule
